### rtl/it_block_tracker_core_assert.svh
// ----------------------------------------------------------------------------
// it_block_tracker_core_assert.svh
// Assertion macros shared by the IT block tracker RTL.
// ----------------------------------------------------------------------------
`ifndef IT_BLOCK_TRACKER_CORE_ASSERT_SVH
`define IT_BLOCK_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ITBT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("IT block tracker check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ITBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("IT block tracker check failed");

`endif

### rtl/itbt_pkg.sv
// ----------------------------------------------------------------------------
// itbt_pkg
// Types and constants of the Thumb-2 IT block tracker.
// ----------------------------------------------------------------------------
package itbt_pkg;

    typedef enum logic [1:0] {
        OP_IT   = 2'd0,
        OP_INSN = 2'd1,
        OP_END  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_MISMATCH     = 2'd1,
        ERR_IT_PENDING   = 2'd2,
        ERR_AREA_PENDING = 2'd3
    } err_t;

    localparam logic [15:0] IT_BASE    = 16'hBF00;
    localparam logic [3:0]  COND_AL    = 4'd14;
    localparam logic [3:0]  MASK_FIRST = 4'h8;
    localparam logic [2:0]  SLOTS_MAX  = 3'd4;

endpackage

### rtl/it_block_tracker_core.sv
// ----------------------------------------------------------------------------
// it_block_tracker_core
// Tracks explicit and implicit Thumb-2 IT blocks over a stream of items and
// produces one result per item: the IT halfword to emit and any error.
//
//   Channel   Direction  Carries
//   s_axis    in         op (tuser); cond, then_else, block_len, is_thumb,
//                        position (tdata)
//   m_axis    out        emit_it (tuser); it_word, it_position, error_code,
//                        al_warning (tdata)
//
// One item is taken every cycle unless a stalled result holds the input register;
// each item passes through the input register and then the result register,
// and its result is valid once it reaches the result register.
// The block state updates as an item moves into the result register.
// A stalled result holds its item, and the input register still takes one
// more item behind it.
// Reset returns the tracker to no open block with condition AL.
// ----------------------------------------------------------------------------
module it_block_tracker_core #(
    parameter int  POSITION_BITS = 24,
    localparam int IN_W          = ((11 + POSITION_BITS + 7) / 8) * 8,
    localparam int OUT_W         = ((19 + POSITION_BITS + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // cond[3:0], then_else[6:4], block_len[9:7], is_thumb[10], position, zero fill
    input  logic [IN_W-1:0]        s_axis_tdata,
    // op[1:0]
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // it_word[15:0], it_position, error_code, al_warning, zero fill
    output logic [OUT_W-1:0]       m_axis_tdata,
    // emit_it
    output logic                   m_axis_tuser
);

    // Input register.
    logic                     in_valid_reg;
    logic [1:0]               in_op_reg;
    logic [3:0]               in_cond_reg;
    logic [2:0]               in_te_reg;
    logic [2:0]               in_len_reg;
    logic                     in_thumb_reg;
    logic [POSITION_BITS-1:0] in_pos_reg;

    // Result register.
    logic                     out_valid_reg;
    logic                     out_emit_reg;
    logic [15:0]              out_word_reg;
    logic [POSITION_BITS-1:0] out_pos_reg;
    logic [1:0]               out_err_reg;
    logic                     out_warn_reg;

    // Block state.
    logic [3:0]               first_cond_reg,  first_cond_next;
    logic [3:0]               then_flags_reg,  then_flags_next;
    logic [2:0]               slot_count_reg,  slot_count_next;
    logic [2:0]               slot_index_reg,  slot_index_next;
    logic                     implicit_reg,    implicit_next;
    logic [POSITION_BITS-1:0] block_pos_reg,   block_pos_next;

    logic                     emit_next;
    logic [1:0]               err_next;
    logic                     warn_next;
    logic [3:0]               mask_next;
    logic [15:0]              word_next;
    logic                     advance;
    logic                     take_in;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        logic       pending;
        logic [2:0] len;
        logic [3:0] len_mask;
        logic [1:0] idx;
        logic [3:0] expect_cond;
        logic       c0;

        pending         = (slot_index_reg != slot_count_reg);
        first_cond_next = first_cond_reg;
        then_flags_next = then_flags_reg;
        slot_count_next = slot_count_reg;
        slot_index_next = slot_index_reg;
        implicit_next   = implicit_reg;
        block_pos_next  = block_pos_reg;
        emit_next       = 1'b0;
        err_next        = itbt_pkg::ERR_NONE;
        warn_next       = 1'b0;
        len             = in_len_reg;
        len_mask        = 4'b0001;
        idx             = slot_index_reg[1:0];
        expect_cond     = first_cond_reg ^ {3'b000, ~then_flags_reg[idx]};

        if (len == 3'd0)
        begin
            len = 3'd1;
        end
        else if (len > itbt_pkg::SLOTS_MAX)
        begin
            len = itbt_pkg::SLOTS_MAX;
        end

        case (len)
            3'd2:    len_mask = 4'b0011;
            3'd3:    len_mask = 4'b0111;
            3'd4:    len_mask = 4'b1111;
            default: len_mask = 4'b0001;
        endcase

        unique case (in_op_reg)
            itbt_pkg::OP_IT:
            begin
                if (pending)
                begin
                    err_next = itbt_pkg::ERR_IT_PENDING;
                end
                warn_next       = (in_cond_reg == itbt_pkg::COND_AL) && (len != 3'd1);
                first_cond_next = in_cond_reg;
                then_flags_next = {in_te_reg, 1'b1} & len_mask;
                slot_count_next = len;
                slot_index_next = 3'd0;
                implicit_next   = 1'b0;
                block_pos_next  = in_pos_reg;
                emit_next       = in_thumb_reg;
            end
            itbt_pkg::OP_INSN:
            begin
                if (pending)
                begin
                    if (in_cond_reg != expect_cond)
                    begin
                        err_next = itbt_pkg::ERR_MISMATCH;
                    end
                    slot_index_next = slot_index_reg + 3'd1;
                end
                else if (implicit_reg && (slot_count_reg != itbt_pkg::SLOTS_MAX))
                begin
                    if (!in_thumb_reg || (in_cond_reg == itbt_pkg::COND_AL))
                    begin
                        first_cond_next = itbt_pkg::COND_AL;
                        then_flags_next = 4'd0;
                        slot_count_next = 3'd0;
                        slot_index_next = 3'd0;
                        implicit_next   = 1'b0;
                        block_pos_next  = '0;
                    end
                    else
                    begin
                        if (in_cond_reg == first_cond_reg)
                        begin
                            then_flags_next[slot_count_reg[1:0]] = 1'b1;
                            slot_count_next = slot_count_reg + 3'd1;
                            slot_index_next = slot_count_reg + 3'd1;
                        end
                        else if (in_cond_reg == (first_cond_reg ^ 4'd1))
                        begin
                            then_flags_next[slot_count_reg[1:0]] = 1'b0;
                            slot_count_next = slot_count_reg + 3'd1;
                            slot_index_next = slot_count_reg + 3'd1;
                        end
                        else
                        begin
                            first_cond_next = in_cond_reg;
                            then_flags_next = 4'b0001;
                            slot_count_next = 3'd1;
                            slot_index_next = 3'd1;
                            implicit_next   = 1'b1;
                            block_pos_next  = in_pos_reg;
                        end
                        emit_next = 1'b1;
                    end
                end
                else if (in_thumb_reg && (in_cond_reg != itbt_pkg::COND_AL))
                begin
                    first_cond_next = in_cond_reg;
                    then_flags_next = 4'b0001;
                    slot_count_next = 3'd1;
                    slot_index_next = 3'd1;
                    implicit_next   = 1'b1;
                    block_pos_next  = in_pos_reg;
                    emit_next       = 1'b1;
                end
            end
            itbt_pkg::OP_END:
            begin
                if (pending)
                begin
                    err_next = itbt_pkg::ERR_AREA_PENDING;
                end
                first_cond_next = itbt_pkg::COND_AL;
                then_flags_next = 4'd0;
                slot_count_next = 3'd0;
                slot_index_next = 3'd0;
                implicit_next   = 1'b0;
                block_pos_next  = '0;
            end
            default:
            begin
            end
        endcase

        // The mask puts slot two at bit 3 and ends with a single one bit.
        c0 = first_cond_next[0];
        case (slot_count_next)
            3'd2:
                mask_next = {~c0 ^ then_flags_next[1], 3'b100};
            3'd3:
                mask_next = {~c0 ^ then_flags_next[1], ~c0 ^ then_flags_next[2], 2'b10};
            3'd4:
                mask_next = {~c0 ^ then_flags_next[1], ~c0 ^ then_flags_next[2],
                             ~c0 ^ then_flags_next[3], 1'b1};
            default:
                mask_next = itbt_pkg::MASK_FIRST;
        endcase
        word_next = itbt_pkg::IT_BASE | {8'h00, first_cond_next, mask_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            first_cond_reg <= itbt_pkg::COND_AL;
            then_flags_reg <= 4'd0;
            slot_count_reg <= 3'd0;
            slot_index_reg <= 3'd0;
            implicit_reg   <= 1'b0;
            block_pos_reg  <= '0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg)
            begin
                first_cond_reg <= first_cond_next;
                then_flags_reg <= then_flags_next;
                slot_count_reg <= slot_count_next;
                slot_index_reg <= slot_index_next;
                implicit_reg   <= implicit_next;
                block_pos_reg  <= block_pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_op_reg    <= s_axis_tuser;
            in_cond_reg  <= s_axis_tdata[3:0];
            in_te_reg    <= s_axis_tdata[6:4];
            in_len_reg   <= s_axis_tdata[9:7];
            in_thumb_reg <= s_axis_tdata[10];
            in_pos_reg   <= s_axis_tdata[10+POSITION_BITS:11];
        end
        if (advance && in_valid_reg)
        begin
            out_emit_reg <= emit_next;
            out_word_reg <= emit_next ? word_next : 16'd0;
            out_pos_reg  <= emit_next ? block_pos_next : '0;
            out_err_reg  <= err_next;
            out_warn_reg <= warn_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_emit_reg;
    assign m_axis_tdata  = OUT_W'({out_warn_reg, out_err_reg, out_pos_reg, out_word_reg});

`include "it_block_tracker_core_assert.svh"

    `ITBT_ASSERT_NOW(a_index_within_count, clk, rst_n, 1'b1,
                     slot_index_reg <= slot_count_reg)
    `ITBT_ASSERT_NOW(a_count_within_max, clk, rst_n, 1'b1,
                     slot_count_reg <= itbt_pkg::SLOTS_MAX)
    `ITBT_ASSERT_NOW(a_implicit_not_pending, clk, rst_n, implicit_reg,
                     slot_index_reg == slot_count_reg)
    `ITBT_ASSERT_NOW(a_emit_word_valid, clk, rst_n, m_axis_tvalid && m_axis_tuser,
                     (m_axis_tdata[15:8] == itbt_pkg::IT_BASE[15:8]) &&
                     (m_axis_tdata[3:0] != 4'd0))

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for it_block_tracker_core. A queue of stimulus items,
// first a directed set and then random explicit blocks, implicit runs, area
// ends and noise, feeds a stream driver with random gaps. Each accepted
// transfer is run through a local model of the IT block state, and a monitor
// with random stalls compares each result transfer field by field.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IN_BITS    = 40;
    localparam int          OUT_BITS   = 48;
    localparam int          ITEM_COUNT = 1400;
    localparam int          CYCLE_CAP  = 300000;
    localparam logic [1:0]  OP_SPARE   = 2'd3;
    localparam logic [3:0]  COND_NV    = 4'd15;
    localparam logic [23:0] POS_TOP    = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  cond;
        logic [2:0]  then_else;
        logic [2:0]  block_len;
        logic        is_thumb;
        logic [23:0] position;
    } tracker_item_t;

    typedef struct packed {
        logic        emit_it;
        logic [15:0] it_word;
        logic [23:0] it_position;
        logic [1:0]  error_code;
        logic        al_warning;
    } tracker_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata = '0;
    logic [1:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    tracker_item_t   stim_items[$];
    tracker_result_t expected_results[$];
    tracker_item_t   item_on_bus;
    int              error_count = 0;
    int              cycle_count = 0;
    int              sent_count = 0;

    logic [3:0]  blk_first_cond = itbt_pkg::COND_AL;
    logic [3:0]  blk_then_flags = '0;
    logic [2:0]  blk_slot_count = '0;
    logic [2:0]  blk_slot_index = '0;
    logic        blk_implicit = 1'b0;
    logic [23:0] blk_position = '0;

    it_block_tracker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [23:0] pick_position();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return POS_TOP;
        return 24'($urandom);
    endfunction

    function automatic tracker_item_t make_item(logic [1:0] op, logic [3:0] cond,
                                                logic [2:0] then_else,
                                                logic [2:0] block_len,
                                                logic is_thumb, logic [23:0] position);
        tracker_item_t it;
        it.op = op;
        it.cond = cond;
        it.then_else = then_else;
        it.block_len = block_len;
        it.is_thumb = is_thumb;
        it.position = position;
        return it;
    endfunction

    function automatic logic [15:0] it_halfword();
        logic [3:0] mask;
        logic       bit_k;
        logic [1:0] bit_idx;
        int         k;
        mask = itbt_pkg::MASK_FIRST;
        for (k = int'(blk_slot_count); k > 1; k--)
        begin
            bit_idx = 2'(k - 1);
            bit_k = ~blk_first_cond[0] ^ blk_then_flags[bit_idx];
            mask = {bit_k, mask[3:1]};
        end
        return itbt_pkg::IT_BASE | {8'd0, blk_first_cond, 4'd0} | {12'd0, mask};
    endfunction

    task automatic clear_block();
        blk_first_cond = itbt_pkg::COND_AL;
        blk_then_flags = '0;
        blk_slot_count = '0;
        blk_slot_index = '0;
        blk_implicit = 1'b0;
        blk_position = '0;
    endtask

    task automatic open_implicit(input logic [3:0] cond, input logic [23:0] position);
        blk_first_cond = cond;
        blk_then_flags = 4'd1;
        blk_slot_count = 3'd1;
        blk_slot_index = 3'd1;
        blk_implicit = 1'b1;
        blk_position = position;
    endtask

    // Advances the block state by one item and queues the result it produces.
    task automatic track_item(input tracker_item_t it);
        tracker_result_t res;
        logic            pending;
        logic [2:0]      len;
        logic [4:0]      len_mask;
        logic [1:0]      idx;
        logic [3:0]      want;
        res = '0;
        pending = (blk_slot_index != blk_slot_count);
        case (it.op)
            itbt_pkg::OP_IT:
            begin
                len = it.block_len;
                if (len == 3'd0)
                    len = 3'd1;
                if (len > itbt_pkg::SLOTS_MAX)
                    len = itbt_pkg::SLOTS_MAX;
                if (pending)
                    res.error_code = itbt_pkg::ERR_IT_PENDING;
                if (it.cond == itbt_pkg::COND_AL && len != 3'd1)
                    res.al_warning = 1'b1;
                len_mask = (5'd1 << len) - 5'd1;
                blk_first_cond = it.cond;
                blk_then_flags = {it.then_else, 1'b1} & len_mask[3:0];
                blk_slot_count = len;
                blk_slot_index = '0;
                blk_implicit = 1'b0;
                blk_position = it.position;
                res.emit_it = it.is_thumb;
            end
            itbt_pkg::OP_INSN:
            begin
                if (pending)
                begin
                    idx = blk_slot_index[1:0];
                    want = blk_first_cond ^ {3'd0, ~blk_then_flags[idx]};
                    if (it.cond != want)
                        res.error_code = itbt_pkg::ERR_MISMATCH;
                    blk_slot_index = blk_slot_index + 3'd1;
                end
                else if (blk_implicit && blk_slot_count != itbt_pkg::SLOTS_MAX)
                begin
                    if (!it.is_thumb || it.cond == itbt_pkg::COND_AL)
                        clear_block();
                    else
                    begin
                        idx = blk_slot_count[1:0];
                        if (it.cond == blk_first_cond)
                        begin
                            blk_then_flags[idx] = 1'b1;
                            blk_slot_count = blk_slot_count + 3'd1;
                            blk_slot_index = blk_slot_count;
                        end
                        else if (it.cond == (blk_first_cond ^ 4'd1))
                        begin
                            blk_then_flags[idx] = 1'b0;
                            blk_slot_count = blk_slot_count + 3'd1;
                            blk_slot_index = blk_slot_count;
                        end
                        else
                            open_implicit(it.cond, it.position);
                        res.emit_it = 1'b1;
                    end
                end
                else if (it.is_thumb && it.cond != itbt_pkg::COND_AL)
                begin
                    open_implicit(it.cond, it.position);
                    res.emit_it = 1'b1;
                end
            end
            itbt_pkg::OP_END:
            begin
                if (pending)
                    res.error_code = itbt_pkg::ERR_AREA_PENDING;
                clear_block();
            end
            default:
            begin
            end
        endcase
        if (res.emit_it)
        begin
            res.it_word = it_halfword();
            res.it_position = blk_position;
        end
        expected_results.push_back(res);
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, label, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic fire;
        logic next_valid;
        int   gap_left;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            gap_left = 0;
        end
        else
        begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire)
                track_item(item_on_bus);
            if (!s_axis_tvalid || fire)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (stim_items.size() > 0)
                begin
                    item_on_bus = stim_items.pop_front();
                    s_axis_tdata <= {5'd0, item_on_bus.position, item_on_bus.is_thumb,
                                     item_on_bus.block_len, item_on_bus.then_else,
                                     item_on_bus.cond};
                    s_axis_tuser <= item_on_bus.op;
                    next_valid = 1'b1;
                    sent_count++;
                    gap_left = ((sent_count / 150) % 3 == 2) ? 0 : pick_gap();
                end
                s_axis_tvalid <= next_valid;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        tracker_result_t want;
        int              stall_left;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result transfer with no expected result, actual 0x%0h",
                             $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("emit_it", 32'(want.emit_it), 32'(m_axis_tuser));
                    check_field("it_word", 32'(want.it_word), 32'(m_axis_tdata[15:0]));
                    check_field("it_position", 32'(want.it_position),
                                32'(m_axis_tdata[39:16]));
                    check_field("error_code", 32'(want.error_code),
                                32'(m_axis_tdata[41:40]));
                    check_field("al_warning", 32'(want.al_warning),
                                32'(m_axis_tdata[42]));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ((cycle_count / 400) % 3 != 1 && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [3:0] cond;
        logic [3:0] base;
        logic [3:0] want;
        logic [2:0] then_else;
        logic [2:0] len;
        logic       then_bit;
        int         slots;
        int         roll;
        int         i;

        // Directed items.
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd0, 3'd0, 3'd1, 1'b1, 24'd0));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd0, 3'd0, 3'd1, 1'b1, 24'd2));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd1, 3'd0, 3'd1, 1'b1, 24'd4));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd0, 3'd0, 3'd1, 1'b1, 24'd6));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd1, 3'd0, 3'd1, 1'b1, 24'd8));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd5, 3'd0, 3'd1, 1'b1, POS_TOP));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd4, 3'd0, 3'd1, 1'b1, 24'd12));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, itbt_pkg::COND_AL, 3'd0, 3'd1,
                                       1'b1, 24'd14));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd3, 3'd0, 3'd1, 1'b1, 24'd16));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd3, 3'd0, 3'd1, 1'b0, 24'd18));
        stim_items.push_back(make_item(itbt_pkg::OP_IT, 4'd10, 3'd7, 3'd0, 1'b1, POS_TOP));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd10, 3'd0, 3'd0, 1'b1, 24'd20));
        stim_items.push_back(make_item(itbt_pkg::OP_IT, itbt_pkg::COND_AL, 3'd5, 3'd7,
                                       1'b1, 24'd22));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, itbt_pkg::COND_AL, 3'd0, 3'd0,
                                       1'b1, 24'd24));
        stim_items.push_back(make_item(itbt_pkg::OP_IT, COND_NV, 3'd2, 3'd4, 1'b0, 24'd26));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, COND_NV, 3'd0, 3'd0, 1'b1, 24'd28));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, COND_NV, 3'd0, 3'd0, 1'b1, 24'd30));
        stim_items.push_back(make_item(itbt_pkg::OP_END, 4'd0, 3'd7, 3'd7, 1'b1, POS_TOP));
        stim_items.push_back(make_item(itbt_pkg::OP_IT, 4'd1, 3'd0, 3'd3, 1'b1, 24'd0));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd1, 3'd0, 3'd0, 1'b1, 24'd2));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd0, 3'd0, 3'd0, 1'b1, 24'd4));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd0, 3'd0, 3'd0, 1'b1, 24'd6));
        stim_items.push_back(make_item(OP_SPARE, 4'd15, 3'd7, 3'd7, 1'b1, POS_TOP));
        stim_items.push_back(make_item(itbt_pkg::OP_INSN, 4'd7, 3'd0, 3'd0, 1'b1, 24'd8));
        stim_items.push_back(make_item(itbt_pkg::OP_END, 4'd0, 3'd0, 3'd0, 1'b0, 24'd0));

        // Random part: mostly well formed blocks with random content.
        while (stim_items.size() < ITEM_COUNT)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                cond = 4'($urandom_range(0, 15));
                then_else = 3'($urandom);
                len = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(1, 4));
                stim_items.push_back(make_item(itbt_pkg::OP_IT, cond, then_else, len,
                                               $urandom_range(0, 4) != 0, pick_position()));
                slots = (len == 3'd0) ? 1 : (len > 3'd4) ? 4 : int'(len);
                for (i = 0; i < slots; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        break;
                    then_bit = (i == 0) ? 1'b1 : then_else[2'(i - 1)];
                    want = cond ^ {3'd0, ~then_bit};
                    if ($urandom_range(0, 9) == 0)
                        want = 4'($urandom_range(0, 15));
                    stim_items.push_back(make_item(itbt_pkg::OP_INSN, want, 3'($urandom),
                                                   3'($urandom), 1'($urandom),
                                                   pick_position()));
                end
                if ($urandom_range(0, 4) == 0)
                    stim_items.push_back(make_item(itbt_pkg::OP_END, 4'($urandom),
                                                   3'($urandom), 3'($urandom),
                                                   1'($urandom), pick_position()));
            end
            else if (roll < 75)
            begin
                base = 4'($urandom_range(0, 15));
                slots = $urandom_range(1, 6);
                for (i = 0; i < slots; i++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 45)
                        cond = base;
                    else if (roll < 85)
                        cond = base ^ 4'd1;
                    else
                        cond = 4'($urandom_range(0, 15));
                    stim_items.push_back(make_item(itbt_pkg::OP_INSN, cond, 3'($urandom),
                                                   3'($urandom),
                                                   $urandom_range(0, 9) != 0,
                                                   pick_position()));
                end
            end
            else if (roll < 85)
                stim_items.push_back(make_item(itbt_pkg::OP_END, 4'($urandom), 3'($urandom),
                                               3'($urandom), 1'($urandom),
                                               pick_position()));
            else
                stim_items.push_back(make_item(2'($urandom_range(0, 3)), 4'($urandom),
                                               3'($urandom), 3'($urandom), 1'($urandom),
                                               pick_position()));
        end

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
